// ----- sv/sldf_pkg.sv -----
// ----------------------------------------------------------------------------
// sldf_pkg
// Shared types, constants and the CRC-8 byte update for the sync/length
// CRC-8 deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sldf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned KindW   = 2;

  localparam logic [ByteW-1:0] SyncByte      = 8'hBB;
  localparam logic [ByteW-1:0] CrcPoly       = 8'h07;
  localparam logic [LenW-1:0]  MaxPayloadRst = 16'd512;
  localparam logic [ByteW-1:0] CmdKnownLo    = 8'd1;
  localparam logic [ByteW-1:0] CmdKnownHi    = 8'd4;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_CRC = 2'd2,
    KIND_DROP    = 2'd3
  } sldf_kind_e;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_CMD     = 6'b000010,
    PH_LEN_LO  = 6'b000100,
    PH_LEN_HI  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CRC     = 6'b100000
  } sldf_phase_e;

  // One result word
  typedef struct packed {
    sldf_kind_e        kind;
    logic [ByteW-1:0]  payload_byte;
    logic [ByteW-1:0]  command;
    logic [LenW-1:0]   frame_length;
    logic              known_command;
  } sldf_result_t;

  // MSB-first CRC-8 update of one byte, no reflection
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sldf_in_reg.sv -----
// ----------------------------------------------------------------------------
// sldf_in_reg
// Input register: captures one received byte and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sldf_in_reg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [sldf_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic                     adv_i,
  output logic                          vld_o,
  output logic [sldf_pkg::ByteW-1:0]    byte_o
);
  import sldf_pkg::*;

  logic             vld_q, vld_d;
  logic [ByteW-1:0] byte_q;

  // Stall while a held word cannot move on
  assign in_stall_o = vld_q && !adv_i;
  assign vld_d      = in_stall_o ? vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Load a new word whenever one is accepted
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ----- sv/sldf_parser.sv -----
// ----------------------------------------------------------------------------
// sldf_parser
// Frame parser: phase machine, header capture, payload count and running
// CRC-8. Advances by one byte when step_i is high and produces at most one
// result for that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sldf_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [sldf_pkg::ByteW-1:0] byte_i,
  input  wire logic [sldf_pkg::LenW-1:0]  max_payload_i,
  output logic                           res_vld_o,
  output sldf_pkg::sldf_result_t         res_o
);
  import sldf_pkg::*;

  sldf_phase_e      phase_q, phase_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  seen_q, seen_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] crc_next;
  logic [LenW-1:0]  seen_inc;
  logic             known;

  assign crc_next = crc8_update(crc_q, byte_i);
  assign seen_inc = seen_q + LenW'(1);
  assign known    = (cmd_q >= CmdKnownLo) && (cmd_q <= CmdKnownHi);

  // Next state and result for the current byte
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    seen_d    = seen_q;
    crc_d     = crc_q;
    res_vld_o = 1'b0;
    res_o     = '{kind: KIND_PAYLOAD, payload_byte: '0, command: cmd_q,
                  frame_length: len_q, known_command: 1'b0};
    unique case (phase_q)
      PH_CMD: begin
        cmd_d   = byte_i;
        crc_d   = crc_next;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {{(LenW-ByteW){1'b0}}, byte_i};
        crc_d   = crc_next;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d  = {byte_i, len_q[ByteW-1:0]};
        crc_d  = crc_next;
        seen_d = '0;
        res_o.frame_length = len_d;
        if (len_d > max_payload_i) begin
          phase_d    = PH_HUNT;
          res_vld_o  = 1'b1;
          res_o.kind = KIND_DROP;
        end else if (len_d == '0) begin
          phase_d = PH_CRC;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_d  = crc_next;
        seen_d = seen_inc;
        if (seen_inc >= len_q) begin
          phase_d = PH_CRC;
        end
        res_vld_o          = 1'b1;
        res_o.payload_byte = byte_i;
      end
      PH_CRC: begin
        phase_d   = PH_HUNT;
        res_vld_o = 1'b1;
        if (byte_i == crc_q) begin
          res_o.kind          = KIND_GOOD;
          res_o.known_command = known;
        end else begin
          res_o.kind = KIND_BAD_CRC;
        end
      end
      default: begin
        // Hunting, and any stray code: look for sync
        phase_d = PH_HUNT;
        if (byte_i == SyncByte) begin
          crc_d   = crc8_update('0, byte_i);
          phase_d = PH_CMD;
        end
      end
    endcase
  end

  // Advance the parser state on each byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cmd_q   <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      crc_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      crc_q   <= crc_d;
    end
  end

  // Payload count stays below the declared length while in the payload
  a_seen_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> seen_q < len_q)
    else $error("payload count reached declared length inside payload");

  // A dropped frame sends the parser back to hunting
  a_drop_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_vld_o && res_o.kind == KIND_DROP |=> phase_q == PH_HUNT)
    else $error("parser did not resume hunting after drop");

  // Known-command flag only on good frames
  a_known_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.known_command |-> res_o.kind == KIND_GOOD)
    else $error("known_command set on a non-good result");

endmodule

`default_nettype wire

// ----- sv/sldf_out_reg.sv -----
// ----------------------------------------------------------------------------
// sldf_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sldf_out_reg (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire logic                    res_vld_i,
  input  wire sldf_pkg::sldf_result_t  res_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output sldf_pkg::sldf_result_t       res_o
);
  import sldf_pkg::*;

  logic         vld_q, vld_d;
  sldf_result_t res_q;

  // Room when empty or when the held word leaves this cycle
  assign free_o = !vld_q || !out_stall_i;
  assign vld_d  = free_o ? (load_i && res_vld_i) : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture a new result
  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- sv/sync_length_crc8_deframer_core.sv -----
// ----------------------------------------------------------------------------
// sync_length_crc8_deframer_core
// Parses 0xBB / command / 16-bit LE length / payload / CRC-8 frames from a
// byte stream, one byte per cycle while out_stall_i is low.
// ----------------------------------------------------------------------------
// Accepts one byte per clock cycle while out_stall_i is low. A byte passes
// through an input register, is parsed (phase step plus one CRC-8 byte
// update) and its result, if any, lands in the result register once that
// register has room. in_stall_o rises only when both the input register
// and the result register are occupied and out_stall_i is high; it follows
// out_stall_i combinationally through the two stages. Bytes that give no
// result (sync, header, hunting) also wait in the input register until the
// result register has room. max_payload, reset to 512, must be written
// through cfg_we_i while no frame is in flight; the block does not enforce it.
`default_nettype none

module sync_length_crc8_deframer_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sldf_pkg::LenW-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [sldf_pkg::ByteW-1:0]  rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [sldf_pkg::KindW-1:0]       kind_o,
  output logic [sldf_pkg::ByteW-1:0]       payload_byte_o,
  output logic [sldf_pkg::ByteW-1:0]       command_o,
  output logic [sldf_pkg::LenW-1:0]        frame_length_o,
  output logic                             known_command_o
);
  import sldf_pkg::*;

  logic [LenW-1:0]  max_payload_q;
  logic             in_vld;
  logic [ByteW-1:0] in_byte;
  logic             out_free;
  logic             step;
  logic             res_vld;
  sldf_result_t     res;
  sldf_result_t     out_res;

  // Hold the payload limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadRst;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  // Advance a held byte when the result register has room
  assign step = in_vld && out_free;

  sldf_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .adv_i      (out_free),
    .vld_o      (in_vld),
    .byte_o     (in_byte)
  );

  sldf_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (in_byte),
    .max_payload_i (max_payload_q),
    .res_vld_o     (res_vld),
    .res_o         (res)
  );

  sldf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o          = out_res.kind;
  assign payload_byte_o  = out_res.payload_byte;
  assign command_o       = out_res.command;
  assign frame_length_o  = out_res.frame_length;
  assign known_command_o = out_res.known_command;

endmodule

`default_nettype wire
